### hw/rtl/rle_decimal_encoder_core_defines.svh
// Assertion macros used by the encoder port checker.
`ifndef RLE_DECIMAL_ENCODER_CORE_DEFINES_SVH
`define RLE_DECIMAL_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RLEDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlede check failed");

// Next-cycle implication, disabled during reset.
`define RLEDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlede check failed");

`endif

### hw/rtl/rlede_pkg.sv
// Shared types and constants of the run-length decimal encoder.
package rlede_pkg;

    localparam int MAX_RUN_DEF = 65535;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 16;
    localparam int NDIG        = 5;
    localparam int NDIG_W      = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 16-bit x
    localparam logic [CNT_W-1:0] RECIP10     = 16'd52429;
    localparam int               RECIP_SHIFT = 19;

    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] value;
        logic              burst_end;
        logic              stream_end;
    } cmd_t;

    typedef struct packed {
        logic [1:0] n;
        cmd_t       c0;
        cmd_t       c1;
    } push_t;

    typedef struct packed {
        digit_t [NDIG-1:0]  dig;
        logic [NDIG_W-1:0]  nd;
        logic [BYTE_W-1:0]  value;
        logic               burst_end;
        logic               stream_end;
    } burst_t;

endpackage

### hw/rtl/rle_decimal_encoder_core.sv
// Top level of the run-length encoder with ASCII decimal counts.
// Input channel: one raw byte per beat (data_byte), final_byte marks the end
// of a stream. A beat is taken when in_valid is high and in_stall is low.
// Output channel: one encoded byte per beat on out_byte; a run comes out as
// its length in decimal digits, high digit first, then the run byte.
// burst_end marks the last byte caused by an input beat, stream_end the
// last byte of the stream. A run reaching MAX_RUN is sent and restarted.
// Path: the beat that closes a run writes the command queue, the converter
// pops it, then the output register loads its digits and run byte; the
// digit loop in the converter makes one digit per cycle.
// Throughput: the output port sends one byte per cycle unless out_stall is
// high. Input beats that extend a run are taken every cycle unless in_stall
// is high; when every byte differs, the output port sets the pace. The
// four-entry queue holds in_stall high while fewer than two entries are free.
// Reset clears the run and empties the queue and output register.
// While out_stall is high the shown byte holds and the queue fills;
// then in_stall rises.
module rle_decimal_encoder_core #(
    parameter int MAX_RUN = rlede_pkg::MAX_RUN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rlede_pkg::BYTE_W-1:0] data_byte,
    input  logic                         final_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rlede_pkg::BYTE_W-1:0] out_byte,
    output logic                         burst_end,
    output logic                         stream_end
);

    rlede_pkg::push_t  push;
    rlede_pkg::cmd_t   q_head;
    rlede_pkg::burst_t bst;
    logic              accept;
    logic              q_valid;
    logic              pop;
    logic              bst_valid;
    logic              em_free;

    assign accept = in_valid && !in_stall;

    rlede_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push)
    );

    rlede_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pop         (pop),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .almost_full (in_stall)
    );

    rlede_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .em_free   (em_free),
        .bst_valid (bst_valid),
        .bst       (bst)
    );

    rlede_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .bst_valid  (bst_valid),
        .bst        (bst),
        .em_free    (em_free),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .burst_end  (burst_end),
        .stream_end (stream_end)
    );

endmodule

### hw/rtl/rlede_front.sv
// Front end: run tracking and classification of input beats into emit commands.
module rlede_front #(
    parameter int MAX_RUN = rlede_pkg::MAX_RUN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [rlede_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          final_byte,
    output rlede_pkg::push_t              push
);

    logic [rlede_pkg::BYTE_W-1:0] run_value_reg, run_value_next;
    logic [rlede_pkg::CNT_W-1:0]  run_count_reg, run_count_next;
    logic                         run_open_reg, run_open_next;
    logic [rlede_pkg::CNT_W:0]    cnt_inc;
    logic                         match;
    logic                         sat;
    logic                         one_sat;
    logic                         flush_new;
    rlede_pkg::cmd_t              new_cmd;

    assign cnt_inc = {1'b0, run_count_reg} + 17'd1;
    assign match   = run_open_reg && (data_byte == run_value_reg);
    assign sat     = cnt_inc >= 17'(MAX_RUN);
    assign one_sat = 17'd1 >= 17'(MAX_RUN);
    assign flush_new = final_byte || one_sat;

    always_comb
    begin
        new_cmd.count      = 16'd1;
        new_cmd.value      = data_byte;
        new_cmd.burst_end  = 1'b1;
        new_cmd.stream_end = final_byte;
    end

    always_comb
    begin
        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        run_open_next  = run_open_reg;
        push           = '0;
        if (accept)
        begin
            if (match)
            begin
                if (sat || final_byte)
                begin
                    push.n               = 2'd1;
                    push.c0.count        = cnt_inc[rlede_pkg::CNT_W-1:0];
                    push.c0.value        = run_value_reg;
                    push.c0.burst_end    = 1'b1;
                    push.c0.stream_end   = final_byte;
                    run_open_next        = 1'b0;
                    run_count_next       = '0;
                end
                else
                begin
                    run_count_next = cnt_inc[rlede_pkg::CNT_W-1:0];
                end
            end
            else
            begin
                if (run_open_reg)
                begin
                    push.n             = 2'd1;
                    push.c0.count      = run_count_reg;
                    push.c0.value      = run_value_reg;
                    push.c0.burst_end  = !flush_new;
                    push.c0.stream_end = 1'b0;
                end
                run_value_next = data_byte;
                run_count_next = 16'd1;
                run_open_next  = 1'b1;
                if (flush_new)
                begin
                    if (run_open_reg)
                    begin
                        push.c1 = new_cmd;
                        push.n  = 2'd2;
                    end
                    else
                    begin
                        push.c0 = new_cmd;
                        push.n  = 2'd1;
                    end
                    run_open_next  = 1'b0;
                    run_count_next = '0;
                end
            end
            if (final_byte)
            begin
                run_open_next  = 1'b0;
                run_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg <= '0;
            run_count_reg <= '0;
            run_open_reg  <= 1'b0;
        end
        else
        begin
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
            run_open_reg  <= run_open_next;
        end
    end

endmodule

### hw/rtl/rlede_queue.sv
// Command queue between front and back: up to two writes and one read per cycle.
module rlede_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  rlede_pkg::push_t push,
    input  logic             pop,
    output logic             q_valid,
    output rlede_pkg::cmd_t  q_head,
    output logic             almost_full
);

    rlede_pkg::cmd_t                  mem_reg [rlede_pkg::QDEPTH];
    logic [rlede_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rlede_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rlede_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic [rlede_pkg::QPTR_W-1:0]     wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign q_valid     = cnt_reg != '0;
    assign q_head      = mem_reg[rd_ptr_reg];
    assign almost_full = cnt_reg > rlede_pkg::QCNT_W'(rlede_pkg::QDEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + rlede_pkg::QPTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + rlede_pkg::QPTR_W'(pop);
    assign cnt_next    = cnt_reg + rlede_pkg::QCNT_W'(push.n) - rlede_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.c0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.c1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hw/rtl/rlede_conv.sv
// Back end, first half: binary count to decimal digits, one digit per cycle.
module rlede_conv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rlede_pkg::cmd_t   q_head,
    output logic              pop,
    input  logic              em_free,
    output logic              bst_valid,
    output rlede_pkg::burst_t bst
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [rlede_pkg::NDIG_W-1:0]         nd_reg;
    logic [rlede_pkg::CNT_W-1:0]          rem_reg;
    rlede_pkg::digit_t [rlede_pkg::NDIG-1:0] dig_reg;
    logic [rlede_pkg::BYTE_W-1:0]         value_reg;
    logic                                 be_reg;
    logic                                 se_reg;
    logic [2*rlede_pkg::CNT_W-1:0]        prod;
    logic [rlede_pkg::CNT_W-1:0]          quot;
    logic [rlede_pkg::CNT_W-1:0]          quot10;
    rlede_pkg::digit_t                    digit;
    logic                                 step;
    logic                                 take;

    assign prod   = 32'(rem_reg) * 32'(rlede_pkg::RECIP10);
    assign quot   = 16'(prod >> rlede_pkg::RECIP_SHIFT);
    assign quot10 = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};
    assign digit  = 4'(rem_reg - quot10);

    assign step      = busy_reg && !done_reg;
    assign bst_valid = done_reg;
    assign take      = done_reg && em_free;
    assign pop       = q_valid && (!busy_reg || take);

    assign bst.dig        = dig_reg;
    assign bst.nd         = nd_reg;
    assign bst.value      = value_reg;
    assign bst.burst_end  = be_reg;
    assign bst.stream_end = se_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            nd_reg   <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            nd_reg   <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (step)
        begin
            nd_reg   <= nd_reg + 1'b1;
            done_reg <= quot == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg   <= (q_head.count == '0) ? 16'd1 : q_head.count;
            value_reg <= q_head.value;
            be_reg    <= q_head.burst_end;
            se_reg    <= q_head.stream_end;
        end
        else if (step)
        begin
            rem_reg <= quot;
        end
        for (int i = 0; i < rlede_pkg::NDIG; i++)
        begin
            if (step && nd_reg == rlede_pkg::NDIG_W'(i))
            begin
                dig_reg[i] <= digit;
            end
        end
    end

endmodule

### hw/rtl/rlede_emit.sv
// Back end, second half: output register that sends digits high first, then the run byte.
module rlede_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         bst_valid,
    input  rlede_pkg::burst_t            bst,
    output logic                         em_free,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [rlede_pkg::BYTE_W-1:0] out_byte,
    output logic                         burst_end,
    output logic                         stream_end
);

    logic                                    valid_reg;
    logic [rlede_pkg::NDIG_W-1:0]            idx_reg;
    logic [rlede_pkg::NDIG_W-1:0]            idx_m1;
    rlede_pkg::digit_t [rlede_pkg::NDIG-1:0] dig_reg;
    logic [rlede_pkg::BYTE_W-1:0]            value_reg;
    logic                                    be_reg;
    logic                                    se_reg;
    logic                                    last;
    logic                                    beat;
    logic                                    load;

    assign last    = idx_reg == '0;
    assign beat    = valid_reg && !out_stall;
    assign em_free = !valid_reg || (last && !out_stall);
    assign load    = bst_valid && em_free;
    assign idx_m1  = idx_reg - 1'b1;

    assign out_valid  = valid_reg;
    assign out_byte   = last ? value_reg : {rlede_pkg::ASCII_DIGIT_HI, dig_reg[idx_m1]};
    assign burst_end  = last && be_reg;
    assign stream_end = last && se_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= bst.nd;
        end
        else if (beat)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dig_reg   <= bst.dig;
            value_reg <= bst.value;
            be_reg    <= bst.burst_end;
            se_reg    <= bst.stream_end;
        end
    end

endmodule

### hw/rtl/rlede_checker.sv
// Port-level checker for the encoder, bound to the top level.
`include "rle_decimal_encoder_core_defines.svh"

module rlede_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [rlede_pkg::BYTE_W-1:0] data_byte,
    input logic                         final_byte,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [rlede_pkg::BYTE_W-1:0] out_byte,
    input logic                         burst_end,
    input logic                         stream_end
);

    logic in_beat;

    assign in_beat = in_valid && !in_stall;

    `RLEDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(burst_end) && $stable(stream_end))
    `RLEDE_ASSERT_IMPL(a_stream_in_burst, clk, rst_n, out_valid && stream_end, burst_end)
    `RLEDE_ASSERT_IMPL(a_out_known, clk, rst_n, out_valid, !$isunknown({out_byte, burst_end, stream_end}))
    `RLEDE_ASSERT_IMPL(a_beat_known, clk, rst_n, in_beat, !$isunknown({data_byte, final_byte}))

endmodule

bind rle_decimal_encoder_core rlede_checker u_rlede_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .burst_end  (burst_end),
    .stream_end (stream_end)
);

### verif/tb_top.sv
// Self-checking testbench for the run-length encoder with ASCII decimal counts.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RUN_LIMIT  = rlede_pkg::MAX_RUN_DEF;
    localparam int          STUCK_MAX  = 2000;
    localparam int          DRAIN_CYC  = 20;
    localparam int unsigned RAND_BEATS = 240;
    localparam int unsigned TAIL_BEATS = 60;

    typedef struct packed {
        logic [rlede_pkg::BYTE_W-1:0] value;
        logic                         burst_end;
        logic                         stream_end;
    } enc_byte_t;

    typedef struct packed {
        logic [7:0]      value;
        logic [16:0]     reps;
        logic            fin;
        logic [2:0]      exp_n;
        logic [0:5][7:0] exp_bytes;
    } dir_row_t;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         in_stall;
    logic [rlede_pkg::BYTE_W-1:0] data_byte  = '0;
    logic                         final_byte = 1'b0;
    logic                         out_valid;
    logic                         out_stall  = 1'b0;
    logic [rlede_pkg::BYTE_W-1:0] out_byte;
    logic                         burst_end;
    logic                         stream_end;

    logic        tail = 1'b0;
    logic [31:0] cyc  = '0;
    logic        idle_ok;
    int          stuck      = 0;
    int          mismatches = 0;

    logic [7:0]  run_byte = '0;
    int unsigned run_len  = 0;
    logic        run_live = 1'b0;

    enc_byte_t expected_out[$];
    enc_byte_t beat_out[$];

    // value, beats, final on last beat, typed result count, typed results
    dir_row_t dir_rows [0:11] = '{
        '{8'h00, 17'd1,     1'b1, 3'd2, {"1", 8'h00}},
        '{8'hFF, 17'd1,     1'b1, 3'd2, {"1", 8'hFF}},
        '{"A",   17'd3,     1'b1, 3'd2, {"3", "A"}},
        '{"0",   17'd10,    1'b1, 3'd3, {"10", "0"}},
        '{8'h31, 17'd1,     1'b0, 3'd0, 48'd0},
        '{8'h32, 17'd9,     1'b0, 3'd0, 48'd0},
        '{8'h33, 17'd99,    1'b0, 3'd0, 48'd0},
        '{8'h34, 17'd100,   1'b1, 3'd4, {"100", 8'h34}},
        '{8'h5A, 17'd2,     1'b0, 3'd0, 48'd0},
        '{8'hA5, 17'd1,     1'b0, 3'd0, 48'd0},
        '{8'h5A, 17'd1,     1'b1, 3'd0, 48'd0},
        '{8'h5A, 17'd4,     1'b1, 3'd2, {"4", 8'h5A}}
    };

    rle_decimal_encoder_core #(
        .MAX_RUN    (RUN_LIMIT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .burst_end  (burst_end),
        .stream_end (stream_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign idle_ok = !tail && (cyc[9:8] != 2'b11);

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic void append_run(input int unsigned len, input logic [7:0] v);
        string digits;
        digits = $sformatf("%0d", len);
        for (int k = 0; k < digits.len(); k++)
        begin
            beat_out.push_back('{digits[k], 1'b0, 1'b0});
        end
        beat_out.push_back('{v, 1'b0, 1'b0});
    endfunction

    function automatic void encode_beat(input logic [7:0] b, input logic fin);
        beat_out.delete();
        if (run_live && b == run_byte)
        begin
            run_len++;
            if (run_len >= RUN_LIMIT || fin)
            begin
                append_run(run_len, run_byte);
                run_live = 1'b0;
                run_len  = 0;
            end
        end
        else
        begin
            if (run_live)
            begin
                append_run(run_len, run_byte);
            end
            run_byte = b;
            run_len  = 1;
            run_live = 1'b1;
            if (fin)
            begin
                append_run(1, b);
                run_live = 1'b0;
                run_len  = 0;
            end
        end
    endfunction

    // typed_n of zero: expected bytes come from the predictor
    task automatic send_beat(input logic [7:0] b, input logic fin,
                             input logic [2:0] typed_n, input logic [0:5][7:0] typed);
        if (idle_ok && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        do @(posedge clk); while (in_stall);
        encode_beat(b, fin);
        if (typed_n != 0)
        begin
            beat_out.delete();
            for (int i = 0; i < typed_n; i++)
            begin
                beat_out.push_back('{typed[6 - typed_n + i], 1'b0, 1'b0});
            end
        end
        if (beat_out.size() != 0)
        begin
            beat_out[beat_out.size() - 1].burst_end  = 1'b1;
            beat_out[beat_out.size() - 1].stream_end = fin;
        end
        foreach (beat_out[i])
        begin
            expected_out.push_back(beat_out[i]);
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : out_check
        enc_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_out.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat out_byte=%h", out_byte));
            end
            else
            begin
                want = expected_out.pop_front();
                if (out_byte !== want.value)
                begin
                    report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.value));
                end
                if (burst_end !== want.burst_end)
                begin
                    report_mismatch($sformatf("burst_end %b, want %b",
                                              burst_end, want.burst_end));
                end
                if (stream_end !== want.stream_end)
                begin
                    report_mismatch($sformatf("stream_end %b, want %b",
                                              stream_end, want.stream_end));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck <= 0;
        end
        else if (stuck >= STUCK_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stuck <= stuck + 1;
        end
    end

    initial
    begin : out_pace
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_ok && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        logic [7:0]  v;
        logic        fin;
        sent = 0;
        v    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            for (int unsigned k = 1; k <= dir_rows[r].reps; k++)
            begin
                send_beat(dir_rows[r].value, dir_rows[r].fin && k == dir_rows[r].reps,
                          (k == dir_rows[r].reps) ? dir_rows[r].exp_n : 3'd0,
                          dir_rows[r].exp_bytes);
            end
        end

        // runs of random content, mostly short, some across digit-count boundaries
        while (sent < RAND_BEATS)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 1)
            begin
                v = 8'($urandom_range(0, 3));
            end
            else if (pick > 1)
            begin
                v = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                len = $urandom_range(1, 4);
            end
            else if (pick < 19)
            begin
                len = $urandom_range(5, 20);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       len = 9;
                    1:       len = 10;
                    2:       len = 99;
                    default: len = 100;
                endcase
            end
            fin = ($urandom_range(0, 5) == 0);
            for (int unsigned k = 1; k <= len; k++)
            begin
                send_beat(v, fin && k == len, 3'd0, 48'd0);
            end
            sent += len;
            tail = (sent + TAIL_BEATS >= RAND_BEATS);
        end
        in_valid <= 1'b0;

        while (expected_out.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rlede_pkg.sv
hw/rtl/rlede_front.sv
hw/rtl/rlede_queue.sv
hw/rtl/rlede_conv.sv
hw/rtl/rlede_emit.sv
hw/rtl/rle_decimal_encoder_core.sv
hw/rtl/rlede_checker.sv
verif/tb_top.sv
